/* hw/rtl/bsc_pkg.sv */
// Shared codes and controller/datapath command and status types of the safety check.
package bsc_pkg;

    // Request kinds carried in the input tuser field
    localparam logic [1:0] REQ_MAX   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_AVAIL = 2'd2;
    localparam logic [1:0] REQ_RUN   = 2'd3;

    // Configuration port
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 8;
    localparam logic [CFG_IW-1:0] CFG_PROCS = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_RES   = 1'b1;

    localparam int CNT_W  = 16;
    localparam int PID_W  = 4;
    localparam int REQ_W  = 2;
    localparam int PIDX_W = 4;
    localparam int RIDX_W = 3;
    localparam int PROCS_W = 5;
    localparam int RES_W   = 4;
    localparam logic [PROCS_W-1:0] PROCS_RST = 5'd16;
    localparam logic [RES_W-1:0]   RES_RST   = 4'd8;

    typedef struct packed {
        logic wr_max;     // load one max-claim entry
        logic wr_alloc;   // load one allocation entry
        logic wr_avail;   // load one available count
        logic copy;       // working vector <= available vector
        logic chk_clr;    // clear the need-check fail flag
        logic chk_rd;     // read one entry pair for the need check
        logic rel_rd;     // read one allocation entry for release
        logic emit_proc;  // load a finished-process item into the output register
        logic emit_verd;  // load the verdict item into the output register
        logic safe;       // verdict bit, valid with emit_verd
    } t_cmd;

    typedef struct packed {
        logic fail;       // some need exceeded the working count
        logic out_free;   // output register can take an item this cycle
    } t_sts;

endpackage

/* hw/rtl/bankers_safety_check.sv */
// Top level of the banker's-algorithm safety check: ports, field packing and checks.
//
// Input stream (s side): each transfer is one request. tuser holds the request kind:
// load max claim, load allocation, load available count, or run the check. A load
// gives no result. A run copies the available vector into the working vector and
// walks the processes in index order, pass after pass, until a pass finishes nobody
// or procs_in_use passes are done (procs_in_use is capped at MAX_PROCS).
// Output stream (m side): one transfer per process found able to finish (tuser = 0),
// then one verdict transfer (tuser = 1, tlast = 1) whose safe bit says whether all
// processes in use finished.
// Steps of a run: a done process is skipped; a blocked one gets the need check, with
// registered reads of both matrices, one resource per cycle; a finishing one gets the
// check sweep, then a release sweep through the working-vector adder, then its output
// item. The input is not ready during a run.
// Configuration: separate write channel, index 0 = procs_in_use, 1 = res_in_use,
// always ready; write only while the block is idle. Reset (synchronous, active low)
// sets procs_in_use = 16, res_in_use = 8, clears the working vector and finished flags.
// Matrix contents are not cleared. A stalled receiver holds the output register and
// freezes the run until the item is taken; loads are still accepted while idle.
module bankers_safety_check #(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [3:0] proc_index, [6:4] res_index, [22:7] value, [23] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] proc_id, [4] safe, [7:5] zero
    output logic [0:0]  o_m_tuser,   // [0] is_verdict
    output logic        o_m_tlast,   // last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bsc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [bsc_pkg::CFG_DW-1:0] i_cfg_data
);
    import bsc_pkg::*;

    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [PW-1:0]    w_rd_proc;
    logic [RW-1:0]    w_rd_res;
    logic [PID_W-1:0] w_pid;
    logic [PID_W-1:0] w_out_pid;
    logic             w_out_verd;
    logic             w_out_safe;

    bsc_ctrl #(
        .MAX_PROCS (MAX_PROCS),
        .MAX_RES   (MAX_RES),
        .PW        (PW),
        .RW        (RW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_req_type  (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .o_rd_proc   (w_rd_proc),
        .o_rd_res    (w_rd_res),
        .o_pid       (w_pid)
    );

    bsc_dp #(
        .MAX_PROCS (MAX_PROCS),
        .MAX_RES   (MAX_RES),
        .PW        (PW),
        .RW        (RW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_proc_index (i_s_tdata[3:0]),
        .i_res_index  (i_s_tdata[6:4]),
        .i_value      (i_s_tdata[22:7]),
        .i_rd_proc    (w_rd_proc),
        .i_rd_res     (w_rd_res),
        .i_pid        (w_pid),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_pid    (w_out_pid),
        .o_out_verd   (w_out_verd),
        .o_out_safe   (w_out_safe)
    );

    assign o_m_tdata = {3'b000, w_out_safe, w_out_pid};
    assign o_m_tuser = w_out_verd;
    assign o_m_tlast = w_out_verd;

    // an item is only loaded into the output register when the slot is free
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_proc || w_cmd.emit_verd) |-> w_sts.out_free)
        else $error("result loaded while output register busy");

    // a run transfer closes the input until the verdict has been issued
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == REQ_RUN)) |=> !o_s_tready)
        else $error("input still ready after a run transfer");

    // loads, the vector copy, sweep reads and output loads never overlap
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr_max, w_cmd.wr_alloc, w_cmd.wr_avail, w_cmd.copy,
                  w_cmd.chk_rd, w_cmd.rel_rd, w_cmd.emit_proc, w_cmd.emit_verd}))
        else $error("conflicting datapath commands");

endmodule

/* hw/rtl/bsc_dp.sv */
// Datapath: claim and allocation memories, working vector, need check, release adder, output register.
module bsc_dp #(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8,
    parameter int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    parameter int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsc_pkg::t_cmd             i_cmd,
    output bsc_pkg::t_sts             o_sts,
    input  logic [bsc_pkg::PIDX_W-1:0] i_proc_index,
    input  logic [bsc_pkg::RIDX_W-1:0] i_res_index,
    input  logic [bsc_pkg::CNT_W-1:0]  i_value,
    input  logic [PW-1:0]             i_rd_proc,
    input  logic [RW-1:0]             i_rd_res,
    input  logic [bsc_pkg::PID_W-1:0] i_pid,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [bsc_pkg::PID_W-1:0] o_out_pid,
    output logic                      o_out_verd,
    output logic                      o_out_safe
);
    import bsc_pkg::*;

    localparam int DEPTH = MAX_PROCS * (2 ** RW);

    logic [CNT_W-1:0] mem_max   [DEPTH];
    logic [CNT_W-1:0] mem_alloc [DEPTH];
    logic [CNT_W-1:0] r_avail   [MAX_RES];
    logic [CNT_W-1:0] r_work    [MAX_RES];

    logic [CNT_W-1:0] r_max_q;
    logic [CNT_W-1:0] r_alloc_q;
    logic [RW-1:0]    r_rd_res;
    logic             r_chk_vld;
    logic             r_rel_vld;
    logic             r_fail;

    logic             r_out_vld;
    logic [PID_W-1:0] r_out_pid;
    logic             r_out_verd;
    logic             r_out_safe;

    logic                 w_in_range_p;
    logic                 w_in_range_r;
    logic [PW+RW-1:0]     w_waddr;
    logic [PW+RW-1:0]     w_raddr;
    logic [CNT_W-1:0]     w_work_rd;
    logic signed [CNT_W:0] w_need;
    logic [CNT_W:0]       w_sum;
    logic [CNT_W-1:0]     w_sat;
    logic                 w_out_free;

    assign w_in_range_p = 32'(i_proc_index) < MAX_PROCS;
    assign w_in_range_r = 32'(i_res_index) < MAX_RES;
    assign w_waddr = {PW'(i_proc_index), RW'(i_res_index)};
    assign w_raddr = {i_rd_proc, i_rd_res};

    // write port and registered read port of both matrices
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_max && w_in_range_p && w_in_range_r) begin
            mem_max[w_waddr] <= i_value;
        end
        if (i_cmd.wr_alloc && w_in_range_p && w_in_range_r) begin
            mem_alloc[w_waddr] <= i_value;
        end
        r_max_q   <= mem_max[w_raddr];
        r_alloc_q <= mem_alloc[w_raddr];
        r_rd_res  <= i_rd_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_avail && w_in_range_r) begin
            r_avail[RW'(i_res_index)] <= i_value;
        end
    end

    assign w_work_rd = r_work[r_rd_res];
    assign w_need    = $signed({1'b0, r_max_q}) - $signed({1'b0, r_alloc_q});
    assign w_sum     = {1'b0, w_work_rd} + {1'b0, r_alloc_q};
    assign w_sat     = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_work[k] <= '0;
            end
        end else if (i_cmd.copy) begin
            r_work <= r_avail;
        end else if (r_rel_vld) begin
            r_work[r_rd_res] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
            r_rel_vld <= 1'b0;
            r_fail    <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.chk_rd;
            r_rel_vld <= i_cmd.rel_rd;
            if (i_cmd.chk_clr) begin
                r_fail <= 1'b0;
            end else if (r_chk_vld && (w_need > $signed({1'b0, w_work_rd}))) begin
                r_fail <= 1'b1;
            end
        end
    end

    // output register
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_proc || i_cmd.emit_verd) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_proc || i_cmd.emit_verd) begin
            r_out_pid  <= i_cmd.emit_verd ? '0 : i_pid;
            r_out_verd <= i_cmd.emit_verd;
            r_out_safe <= i_cmd.emit_verd && i_cmd.safe;
        end
    end

    assign o_sts.fail     = r_fail;
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_vld;
    assign o_out_pid      = r_out_pid;
    assign o_out_verd     = r_out_verd;
    assign o_out_safe     = r_out_safe;

endmodule

/* hw/rtl/bsc_ctrl.sv */
// Controller: configuration registers, pass/process/resource sequencing and finished flags.
module bsc_ctrl #(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8,
    parameter int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    parameter int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [bsc_pkg::REQ_W-1:0] i_req_type,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bsc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [bsc_pkg::CFG_DW-1:0] i_cfg_data,
    output bsc_pkg::t_cmd             o_cmd,
    input  bsc_pkg::t_sts             i_sts,
    output logic [PW-1:0]             o_rd_proc,
    output logic [RW-1:0]             o_rd_res,
    output logic [bsc_pkg::PID_W-1:0] o_pid
);
    import bsc_pkg::*;

    localparam int NPW = $clog2(MAX_PROCS + 1);
    localparam int NRW = $clog2(MAX_RES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_CWAIT = 4'd3;
    localparam logic [3:0] S_CDEC  = 4'd4;
    localparam logic [3:0] S_REL   = 4'd5;
    localparam logic [3:0] S_RWAIT = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_VERD  = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [PROCS_W-1:0]   r_procs, n_procs;
    logic [RES_W-1:0]     r_res, n_res;
    logic [MAX_PROCS-1:0] r_done, n_done;
    logic [NPW-1:0]       r_i, n_i;
    logic [NPW-1:0]       r_pass, n_pass;
    logic                 r_prog, n_prog;
    logic [RW-1:0]        r_j, n_j;

    logic [NPW-1:0] w_np;
    logic [NRW-1:0] w_nr;
    logic           w_last_j;
    logic           w_safe;
    logic           w_accept;
    t_cmd           w_cmd;

    assign w_np = (32'(r_procs) > MAX_PROCS) ? NPW'(MAX_PROCS) : NPW'(r_procs);
    assign w_nr = (32'(r_res) > MAX_RES) ? NRW'(MAX_RES) : NRW'(r_res);
    assign w_last_j = (NRW'(r_j) + NRW'(1)) == w_nr;
    assign w_accept = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        w_safe = 1'b1;
        for (int k = 0; k < MAX_PROCS; k++) begin
            if ((k < 32'(w_np)) && !r_done[k]) begin
                w_safe = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_procs = r_procs;
        n_res   = r_res;
        n_done  = r_done;
        n_i     = r_i;
        n_pass  = r_pass;
        n_prog  = r_prog;
        n_j     = r_j;
        w_cmd   = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROCS: n_procs = i_cfg_data[PROCS_W-1:0];
                CFG_RES:   n_res   = i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        REQ_MAX:   w_cmd.wr_max   = 1'b1;
                        REQ_ALLOC: w_cmd.wr_alloc = 1'b1;
                        REQ_AVAIL: w_cmd.wr_avail = 1'b1;
                        REQ_RUN: begin
                            w_cmd.copy = 1'b1;
                            n_done  = '0;
                            n_i     = '0;
                            n_pass  = '0;
                            n_prog  = 1'b0;
                            n_state = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_i >= w_np) begin
                    // end of a pass
                    if (!r_prog || ((r_pass + NPW'(1)) >= w_np)) begin
                        n_state = S_VERD;
                    end else begin
                        n_pass = r_pass + NPW'(1);
                        n_i    = '0;
                        n_prog = 1'b0;
                    end
                end else if (r_done[r_i[PW-1:0]]) begin
                    n_i = r_i + NPW'(1);
                end else if (w_nr == '0) begin
                    n_state = S_EMIT;
                end else begin
                    w_cmd.chk_clr = 1'b1;
                    n_j     = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_cmd.chk_rd = 1'b1;
                if (w_last_j) begin
                    n_state = S_CWAIT;
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_CWAIT: n_state = S_CDEC;
            S_CDEC: begin
                if (i_sts.fail) begin
                    n_i     = r_i + NPW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_j     = '0;
                    n_state = S_REL;
                end
            end
            S_REL: begin
                w_cmd.rel_rd = 1'b1;
                if (w_last_j) begin
                    n_state = S_RWAIT;
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_RWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_proc = 1'b1;
                    n_done[r_i[PW-1:0]] = 1'b1;
                    n_prog  = 1'b1;
                    n_i     = r_i + NPW'(1);
                    n_state = S_SCAN;
                end
            end
            S_VERD: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_verd = 1'b1;
                    w_cmd.safe      = w_safe;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_procs <= PROCS_RST;
            r_res   <= RES_RST;
            r_done  <= '0;
            r_i     <= '0;
            r_pass  <= '0;
            r_prog  <= 1'b0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_procs <= n_procs;
            r_res   <= n_res;
            r_done  <= n_done;
            r_i     <= n_i;
            r_pass  <= n_pass;
            r_prog  <= n_prog;
            r_j     <= n_j;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_cmd       = w_cmd;
    assign o_rd_proc   = r_i[PW-1:0];
    assign o_rd_res    = r_j;
    assign o_pid       = PID_W'(r_i);

endmodule
